### rtl/core/mrr_pkg.sv
package mrr_pkg;

    // Token kinds handed from the framer to the back end
    localparam logic [2:0] K_ADDR  = 3'd0;
    localparam logic [2:0] K_FUNC  = 3'd1;
    localparam logic [2:0] K_DATA  = 3'd2;
    localparam logic [2:0] K_CRCLO = 3'd3;
    localparam logic [2:0] K_CRCHI = 3'd4;

    // Summary status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_UNK  = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_BIT  = 8'h80;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [8:0] flen;   // byte position + 1, used on the closing byte
    } t_token;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  payload_byte;
        logic [7:0]  slave_address;
        logic [6:0]  function_code;
        logic        is_exception;
        logic [1:0]  frame_status;
        logic [15:0] received_crc;
        logic [8:0]  frame_length;
    } t_result;

    // One byte of Modbus CRC-16, reflected, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic fc_known(input logic [6:0] fc);
        return (fc inside {[7'h01:7'h06], 7'h0F, 7'h10});
    endfunction

endpackage

### rtl/core/mrr_front.sv
module mrr_front
    import mrr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [7:0]   i_rx_byte,
    input  logic         i_tok_full,
    output logic         o_full,
    output logic         o_tok_wr,
    output t_token       o_tok
);

    logic [8:0] r_pos, n_pos;
    logic [8:0] r_exp, n_exp;
    logic       w_acc;
    logic [9:0] w_pos2;
    logic [2:0] w_kind;

    assign o_full = i_tok_full;
    assign w_acc  = i_push && !i_tok_full;
    assign w_pos2 = {1'b0, r_pos} + 10'd2;

    // frame length: learned at function byte, or at byte count for reads
    always_comb begin
        n_exp = r_exp;
        if (r_pos == 9'd0) begin
            n_exp = 9'd0;
        end else if (r_pos == 9'd1) begin
            if ((i_rx_byte & EXC_BIT) != 8'h00) begin
                n_exp = 9'd5;
            end else if (i_rx_byte inside {[8'h01:8'h04]}) begin
                n_exp = 9'd0;
            end else if (i_rx_byte inside {8'h05, 8'h06, 8'h0F, 8'h10}) begin
                n_exp = 9'd8;
            end else begin
                n_exp = 9'd4;
            end
        end else if (r_pos == 9'd2 && r_exp == 9'd0) begin
            n_exp = 9'd5 + {1'b0, i_rx_byte};
        end
    end

    always_comb begin
        n_pos = r_pos + 9'd1;
        if (r_pos == 9'd0) begin
            w_kind = K_ADDR;
        end else if (r_pos == 9'd1) begin
            w_kind = K_FUNC;
        end else if (w_pos2 < {1'b0, n_exp}) begin
            w_kind = K_DATA;
        end else if (w_pos2 == {1'b0, n_exp}) begin
            w_kind = K_CRCLO;
        end else begin
            w_kind = K_CRCHI;
            n_pos  = 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 9'd0;
            r_exp <= 9'd0;
        end else if (w_acc) begin
            r_pos <= n_pos;
            r_exp <= (w_kind == K_CRCHI) ? 9'd0 : n_exp;
        end
    end

    assign o_tok_wr   = w_acc;
    assign o_tok.kind = w_kind;
    assign o_tok.data = i_rx_byte;
    assign o_tok.flen = r_pos + 9'd1;

endmodule

### rtl/core/mrr_tokq.sv
module mrr_tokq
    import mrr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_token i_tok,
    input  logic   i_rd,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_tok
);

    t_token     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

### rtl/core/mrr_back.sv
module mrr_back
    import mrr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_tok_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    logic [15:0] r_crc;
    logic [7:0]  r_addr;
    logic [7:0]  r_func;
    logic [7:0]  r_lo;

    t_result     r_buf [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    logic        w_rd;
    logic        w_wr;
    logic        w_pop;
    logic [15:0] w_rcrc;
    t_result     w_res;

    assign w_rd     = i_tok_valid && (r_cnt != 2'd2);
    assign o_tok_rd = w_rd;
    assign w_wr     = w_rd && (i_tok.kind == K_DATA || i_tok.kind == K_CRCHI);
    assign w_pop    = i_pop && (r_cnt != 2'd0);
    assign w_rcrc   = {i_tok.data, r_lo};

    always_comb begin
        w_res               = '0;
        w_res.slave_address = r_addr;
        w_res.function_code = r_func[6:0];
        w_res.is_exception  = r_func[7];
        if (i_tok.kind == K_CRCHI) begin
            w_res.is_summary   = 1'b1;
            w_res.received_crc = w_rcrc;
            w_res.frame_length = i_tok.flen;
            if (!r_func[7] && !fc_known(r_func[6:0])) begin
                w_res.frame_status = ST_UNK;
            end else if (w_rcrc == r_crc) begin
                w_res.frame_status = ST_GOOD;
            end else begin
                w_res.frame_status = ST_BAD;
            end
        end else begin
            w_res.payload_byte = i_tok.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            case (i_tok.kind)
                K_ADDR: begin
                    r_addr <= i_tok.data;
                    r_crc  <= crc_byte(CRC_INIT, i_tok.data);
                end
                K_FUNC: begin
                    r_func <= i_tok.data;
                    r_crc  <= crc_byte(r_crc, i_tok.data);
                end
                K_DATA: begin
                    r_crc <= crc_byte(r_crc, i_tok.data);
                end
                K_CRCLO: begin
                    r_lo <= i_tok.data;
                end
                default: begin
                end
            endcase
        end
        if (w_wr) begin
            r_buf[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_pop};
        end
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_buf[r_rp];

endmodule

### rtl/core/modbus_rtu_response_receiver.sv
// Modbus RTU response receiver.
// Input channel: push/full carries one received byte per word on i_rx_byte.
// A byte is taken on a rising edge with push high and full low.
// Output channel: empty/pop. While empty is low the oldest result is on the
// o_* ports; it leaves on a rising edge with pop high and empty low.
// Each data byte after the function byte gives one payload word; the last
// CRC byte of a frame gives one summary word (o_last = 1) with status,
// received CRC (low byte first on the wire) and frame length.
// Address, function and low CRC bytes give no word.
// A payload or summary word is registered in the token queue, then in the
// result buffer, and can be popped once visible. Throughput: one byte per
// cycle while results are popped, set by the framer counter and the byte-wide
// CRC step in the back end, with 2-entry token and result queues between them.
// Reset (synchronous, i_rst_n low) clears the framer to byte 0 of a frame
// and empties both queues.
// When the consumer stops popping, the result buffer fills, the back end
// holds its token, the token queue fills and full rises; no word is lost.
// Framing relies on counted lengths only: there is no gap timer.
module modbus_rtu_response_receiver
    import mrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_is_summary,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_slave_address,
    output logic [6:0]  o_function_code,
    output logic        o_is_exception,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_received_crc,
    output logic [8:0]  o_frame_length,
    output logic        o_last
);

    // framer -> token queue
    logic    w_tok_wr;
    t_token  w_tok_in;
    logic    w_tok_full;

    // token queue -> back end
    logic    w_tok_valid;
    logic    w_tok_rd;
    t_token  w_tok_out;

    t_result w_res;

    // Front: counts positions, learns the frame length, tags each byte
    mrr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .i_tok_full (w_tok_full),
        .o_full     (full),
        .o_tok_wr   (w_tok_wr),
        .o_tok      (w_tok_in)
    );

    mrr_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tok_wr),
        .i_tok   (w_tok_in),
        .i_rd    (w_tok_rd),
        .o_full  (w_tok_full),
        .o_valid (w_tok_valid),
        .o_tok   (w_tok_out)
    );

    // Back: CRC, held header bytes, result words and output buffer
    mrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok_out),
        .o_tok_rd    (w_tok_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign o_is_summary    = w_res.is_summary;
    assign o_payload_byte  = w_res.payload_byte;
    assign o_slave_address = w_res.slave_address;
    assign o_function_code = w_res.function_code;
    assign o_is_exception  = w_res.is_exception;
    assign o_frame_status  = w_res.frame_status;
    assign o_received_crc  = w_res.received_crc;
    assign o_frame_length  = w_res.frame_length;
    assign o_last          = w_res.is_summary;

endmodule
